### rtl/gsa_pkg.sv
// Shared types and constants for the generational slot allocator.
package gsa_pkg;

    localparam int SLOTS  = 64;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int TAG_W  = 31;

    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

    typedef enum logic [1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_LOOKUP  = 2'd1,
        FUNC_RELEASE = 2'd2,
        FUNC_CLEAR   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic start;
        logic exec;
        logic clr_step;
        logic clr_fin;
    } cmd_t;

    typedef struct packed {
        logic clr_end;
        logic out_busy;
    } status_t;

endpackage

### rtl/gsa_ctrl.sv
// Controller state machine for the generational slot allocator.
module gsa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  gsa_pkg::status_t   stat,
    output gsa_pkg::cmd_t      cmd
);

    gsa_pkg::state_t state_reg;
    gsa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gsa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            gsa_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    if (gsa_pkg::func_t'(func) == gsa_pkg::FUNC_CLEAR)
                    begin
                        state_next = gsa_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        state_next = gsa_pkg::ST_EXEC;
                    end
                end
            end
            gsa_pkg::ST_EXEC:
            begin
                if (!stat.out_busy)
                begin
                    cmd.exec   = 1'b1;
                    state_next = gsa_pkg::ST_IDLE;
                end
            end
            gsa_pkg::ST_CLEAR:
            begin
                if (!stat.clr_end)
                begin
                    cmd.clr_step = 1'b1;
                end
                else if (!stat.out_busy)
                begin
                    cmd.clr_fin = 1'b1;
                    state_next  = gsa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gsa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/gsa_datapath.sv
// Datapath of the slot allocator: slot tables, free list, counters, result register.
module gsa_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gsa_pkg::cmd_t               cmd,
    output gsa_pkg::status_t            stat,
    input  logic [1:0]                  func,
    input  logic [gsa_pkg::SLOT_W-1:0]  slot,
    input  logic [gsa_pkg::TAG_W-1:0]   tag,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        ok,
    output logic [gsa_pkg::SLOT_W-1:0]  out_slot,
    output logic [gsa_pkg::TAG_W-1:0]   out_tag
);

    logic [gsa_pkg::TAG_W-1:0]  tag_mem  [gsa_pkg::SLOTS];
    logic [gsa_pkg::CNT_W-1:0]  link_mem [gsa_pkg::SLOTS];

    gsa_pkg::func_t             func_reg;
    logic [gsa_pkg::SLOT_W-1:0] slot_reg;
    logic [gsa_pkg::TAG_W-1:0]  tag_reg;
    logic [gsa_pkg::TAG_W-1:0]  tag_rd_reg;
    logic [gsa_pkg::CNT_W-1:0]  link_rd_reg;

    logic [gsa_pkg::SLOTS-1:0]  alive_reg,      alive_next;
    logic [gsa_pkg::CNT_W-1:0]  free_head_reg,  free_head_next;
    logic [gsa_pkg::CNT_W-1:0]  used_count_reg, used_count_next;
    logic [gsa_pkg::TAG_W-1:0]  tag_cnt_reg,    tag_cnt_next;
    logic [gsa_pkg::CNT_W-1:0]  clr_idx_reg,    clr_idx_next;
    logic                       out_valid_reg,  out_valid_next;
    logic                       ok_reg,         ok_next;
    logic [gsa_pkg::SLOT_W-1:0] out_slot_reg,   out_slot_next;
    logic [gsa_pkg::TAG_W-1:0]  out_tag_reg,    out_tag_next;

    logic [gsa_pkg::SLOT_W-1:0] rd_addr;
    logic                       have_free;
    logic                       have_new;
    logic [gsa_pkg::SLOT_W-1:0] alloc_pos;
    logic                       handle_ok;
    logic [gsa_pkg::SLOT_W-1:0] clr_pos;

    logic                       tag_we;
    logic [gsa_pkg::SLOT_W-1:0] tag_wa;
    logic                       link_we;
    logic [gsa_pkg::SLOT_W-1:0] link_wa;

    assign rd_addr   = (gsa_pkg::func_t'(func) == gsa_pkg::FUNC_ALLOC)
                       ? free_head_reg[gsa_pkg::SLOT_W-1:0] : slot;
    assign have_free = (free_head_reg < gsa_pkg::SLOTS_CNT);
    assign have_new  = (used_count_reg < gsa_pkg::SLOTS_CNT);
    assign alloc_pos = have_free ? free_head_reg[gsa_pkg::SLOT_W-1:0]
                                 : used_count_reg[gsa_pkg::SLOT_W-1:0];
    assign handle_ok = (gsa_pkg::CNT_W'(slot_reg) < used_count_reg)
                       && alive_reg[slot_reg] && (tag_rd_reg == tag_reg);
    assign clr_pos   = clr_idx_reg[gsa_pkg::SLOT_W-1:0];

    assign stat.clr_end  = (clr_idx_reg >= used_count_reg);
    assign stat.out_busy = out_valid_reg && !out_ready;

    always_comb
    begin
        alive_next      = alive_reg;
        free_head_next  = free_head_reg;
        used_count_next = used_count_reg;
        tag_cnt_next    = tag_cnt_reg;
        clr_idx_next    = clr_idx_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        ok_next         = ok_reg;
        out_slot_next   = out_slot_reg;
        out_tag_next    = out_tag_reg;
        tag_we          = 1'b0;
        tag_wa          = alloc_pos;
        link_we         = 1'b0;
        link_wa         = slot_reg;

        if (cmd.start)
        begin
            clr_idx_next = '0;
        end

        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
            ok_next        = 1'b0;
            out_slot_next  = '0;
            out_tag_next   = '0;
            case (func_reg)
                gsa_pkg::FUNC_ALLOC:
                begin
                    if (have_free || have_new)
                    begin
                        if (have_free)
                        begin
                            free_head_next = (link_rd_reg > gsa_pkg::SLOTS_CNT)
                                             ? gsa_pkg::SLOTS_CNT : link_rd_reg;
                        end
                        else
                        begin
                            used_count_next = used_count_reg + 1'b1;
                        end
                        tag_cnt_next         = tag_cnt_reg + 1'b1;
                        alive_next[alloc_pos] = 1'b1;
                        tag_we               = 1'b1;
                        ok_next              = 1'b1;
                        out_slot_next        = alloc_pos;
                        out_tag_next         = tag_cnt_reg;
                    end
                end
                gsa_pkg::FUNC_LOOKUP:
                begin
                    if (handle_ok)
                    begin
                        ok_next       = 1'b1;
                        out_slot_next = slot_reg;
                        out_tag_next  = tag_reg;
                    end
                end
                gsa_pkg::FUNC_RELEASE:
                begin
                    if (handle_ok)
                    begin
                        alive_next[slot_reg] = 1'b0;
                        link_we              = 1'b1;
                        free_head_next       = gsa_pkg::CNT_W'(slot_reg);
                        ok_next              = 1'b1;
                        out_slot_next        = slot_reg;
                        out_tag_next         = tag_reg;
                    end
                end
                default:
                begin
                    ok_next = 1'b1;
                end
            endcase
        end

        if (cmd.clr_step)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            link_wa      = clr_pos;
            if (alive_reg[clr_pos])
            begin
                alive_next[clr_pos] = 1'b0;
                link_we             = 1'b1;
                free_head_next      = clr_idx_reg;
            end
        end

        if (cmd.clr_fin)
        begin
            out_valid_next = 1'b1;
            ok_next        = 1'b1;
            out_slot_next  = '0;
            out_tag_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg      <= '0;
            free_head_reg  <= gsa_pkg::SLOTS_CNT;
            used_count_reg <= '0;
            tag_cnt_reg    <= '0;
            clr_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            alive_reg      <= alive_next;
            free_head_reg  <= free_head_next;
            used_count_reg <= used_count_next;
            tag_cnt_reg    <= tag_cnt_next;
            clr_idx_reg    <= clr_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg       <= ok_next;
        out_slot_reg <= out_slot_next;
        out_tag_reg  <= out_tag_next;
        if (cmd.start)
        begin
            func_reg    <= gsa_pkg::func_t'(func);
            slot_reg    <= slot;
            tag_reg     <= tag;
            tag_rd_reg  <= tag_mem[rd_addr];
            link_rd_reg <= link_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_wa] <= tag_cnt_reg;
        end
        if (link_we)
        begin
            link_mem[link_wa] <= free_head_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign out_slot  = out_slot_reg;
    assign out_tag   = out_tag_reg;

endmodule

### rtl/generational_slot_allocator_unit.sv
// Top level of the generational slot allocator: controller plus datapath.
// Allocate, lookup and release each read the slot's tag and link from the
// table memories into registers when the item is taken, then check, update
// and load the result register. Clear walks the slots below the used count
// one per cycle, then loads the result register. A result waiting in the
// output register does not stop the next item from being taken; the block
// only holds in its final cycle while that register is still full.
module generational_slot_allocator_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  func,
    input  logic [gsa_pkg::SLOT_W-1:0]  slot,
    input  logic [gsa_pkg::TAG_W-1:0]   tag,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        ok,
    output logic [gsa_pkg::SLOT_W-1:0]  out_slot,
    output logic [gsa_pkg::TAG_W-1:0]   out_tag
);

    gsa_pkg::cmd_t    cmd;
    gsa_pkg::status_t stat;

    gsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .stat     (stat),
        .cmd      (cmd)
    );

    gsa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .func      (func),
        .slot      (slot),
        .tag       (tag),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ok        (ok),
        .out_slot  (out_slot),
        .out_tag   (out_tag)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted while previous item still in progress");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec || cmd.clr_fin) |-> !stat.out_busy)
        else $error("result register loaded while still holding an item");

    a_single_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.exec, cmd.clr_step, cmd.clr_fin}))
        else $error("more than one datapath command in a cycle");

    a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.exec || cmd.clr_fin))
        else $error("result appeared without a completing command");

endmodule
